FILE: src/mbps_pkg.sv
// Shared constants and widths for the metaball pixel shader.
`default_nettype none

package mbps_pkg;

    // Payload widths.
    localparam int COORD_X_W = 11;
    localparam int COORD_Y_W = 10;
    localparam int COLOR_W   = 24;
    localparam int CHAN_W    = 8;

    // Arithmetic widths.
    localparam int DX2_W    = 2 * COORD_X_W;
    localparam int DY2_W    = 2 * COORD_Y_W;
    localparam int D2_W     = DX2_W + 1;
    localparam int QUO_W    = 49;
    localparam int FIELD_W  = 25;
    localparam int SUM_W    = FIELD_W + 1;
    localparam int WEIGHT_W = 16;

    // Configuration port.
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_COL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_COL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [COORD_X_W-1:0] RST_FIRST_X   = 11'd200;
    localparam logic [COORD_Y_W-1:0] RST_FIRST_Y   = 10'd200;
    localparam logic [COORD_X_W-1:0] RST_SECOND_X  = 11'd800;
    localparam logic [COORD_Y_W-1:0] RST_SECOND_Y  = 10'd450;
    localparam logic [COLOR_W-1:0]   RST_FIRST_COL = 24'hEEEE22;
    localparam logic [COLOR_W-1:0]   RST_SECOND_COL = 24'hEE22EE;
    localparam logic [COLOR_W-1:0]   RST_BACKGROUND = 24'h5555AA;

    // Field value for a pixel exactly on a ball centre (1.0 in Q1.24).
    localparam logic [FIELD_W-1:0] FIELD_ONE = 25'h1000000;
    // Threshold 0.005 in Q1.24, rounded up.
    localparam logic [SUM_W-1:0]   SUM_THRESHOLD = 26'd83887;

    // Frame size defaults.
    localparam int DEFAULT_MAX_WIDTH  = 2048;
    localparam int DEFAULT_MAX_HEIGHT = 1024;

endpackage

`default_nettype wire

FILE: src/mbps_field.sv
// Field pipeline of one ball: distance, reciprocal division and square root.
`default_nettype none

module mbps_field (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic [mbps_pkg::COORD_X_W-1:0] px,
    input  wire logic [mbps_pkg::COORD_Y_W-1:0] py,
    input  wire logic [mbps_pkg::COORD_X_W-1:0] bx,
    input  wire logic [mbps_pkg::COORD_Y_W-1:0] by,
    output logic                                out_valid,
    output logic [mbps_pkg::FIELD_W-1:0]        field
);
    import mbps_pkg::*;

    localparam int REM_W  = D2_W + 1;
    localparam int SQ_IN  = QUO_W + 1;
    localparam int SQ_RW  = FIELD_W + 3;
    localparam int SQ_N   = SQ_IN / 2;

    logic [COORD_X_W-1:0] dx_reg;
    logic [COORD_Y_W-1:0] dy_reg;
    logic                 v1_reg;
    logic [DX2_W-1:0]     dx2_reg;
    logic [DY2_W-1:0]     dy2_reg;
    logic                 v2_reg;
    logic [D2_W-1:0]      d2_reg;
    logic                 zero_reg;
    logic                 v3_reg;

    // Absolute coordinate differences.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            dx_reg <= (px >= bx) ? (px - bx) : (bx - px);
            dy_reg <= (py >= by) ? (py - by) : (by - py);
        end
    end

    // Squares of the differences.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            dx2_reg <= dx_reg * dx_reg;
            dy2_reg <= dy_reg * dy_reg;
        end
    end

    // Squared distance and the on-centre flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            d2_reg   <= {1'b0, dx2_reg} + {{(D2_W - DY2_W){1'b0}}, dy2_reg};
            zero_reg <= (dx2_reg == '0) && (dy2_reg == '0);
        end
    end

    // Restoring division of 2^48 by the squared distance, one quotient bit a stage.
    logic [REM_W-1:0] dv_rem_reg  [0:QUO_W-1];
    logic [QUO_W-1:0] dv_quo_reg  [0:QUO_W-1];
    logic [D2_W-1:0]  dv_d2_reg   [0:QUO_W-1];
    logic             dv_zero_reg [0:QUO_W-1];
    logic             dv_v_reg    [0:QUO_W-1];

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        logic [REM_W-1:0] src_rem;
        logic [QUO_W-1:0] src_quo;
        logic [D2_W-1:0]  src_d2;
        logic             src_zero;
        logic             src_v;
        logic [REM_W-1:0] shifted;
        logic             ge;

        if (k == 0) begin : g_first
            assign src_rem  = '0;
            assign src_quo  = '0;
            assign src_d2   = d2_reg;
            assign src_zero = zero_reg;
            assign src_v    = v3_reg;
        end else begin : g_rest
            assign src_rem  = dv_rem_reg[k-1];
            assign src_quo  = dv_quo_reg[k-1];
            assign src_d2   = dv_d2_reg[k-1];
            assign src_zero = dv_zero_reg[k-1];
            assign src_v    = dv_v_reg[k-1];
        end

        // The dividend is a single one in its top bit.
        assign shifted = {src_rem[REM_W-2:0], (k == 0) ? 1'b1 : 1'b0};
        assign ge      = (shifted >= {1'b0, src_d2});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[k] <= 1'b0;
            end else if (en) begin
                dv_v_reg[k] <= src_v;
            end
            if (en) begin
                dv_rem_reg[k]  <= ge ? (shifted - {1'b0, src_d2}) : shifted;
                dv_quo_reg[k]  <= {src_quo[QUO_W-2:0], ge};
                dv_d2_reg[k]   <= src_d2;
                dv_zero_reg[k] <= src_zero;
            end
        end
    end

    // Integer square root of the quotient, one root bit a stage.
    logic [SQ_RW-1:0]   sq_rem_reg  [0:SQ_N-1];
    logic [FIELD_W-1:0] sq_root_reg [0:SQ_N-1];
    logic [SQ_IN-1:0]   sq_val_reg  [0:SQ_N-1];
    logic               sq_zero_reg [0:SQ_N-1];
    logic               sq_v_reg    [0:SQ_N-1];

    for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
        logic [SQ_RW-1:0]   src_rem;
        logic [FIELD_W-1:0] src_root;
        logic [SQ_IN-1:0]   src_val;
        logic               src_zero;
        logic               src_v;
        logic [SQ_RW-1:0]   rem_sh;
        logic [SQ_RW-1:0]   trial;
        logic               ge;

        if (j == 0) begin : g_first
            assign src_rem  = '0;
            assign src_root = '0;
            assign src_val  = {1'b0, dv_quo_reg[QUO_W-1]};
            assign src_zero = dv_zero_reg[QUO_W-1];
            assign src_v    = dv_v_reg[QUO_W-1];
        end else begin : g_rest
            assign src_rem  = sq_rem_reg[j-1];
            assign src_root = sq_root_reg[j-1];
            assign src_val  = sq_val_reg[j-1];
            assign src_zero = sq_zero_reg[j-1];
            assign src_v    = sq_v_reg[j-1];
        end

        assign rem_sh = {src_rem[SQ_RW-3:0], src_val[SQ_IN-1 -: 2]};
        assign trial  = {1'b0, src_root, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[j] <= 1'b0;
            end else if (en) begin
                sq_v_reg[j] <= src_v;
            end
            if (en) begin
                sq_rem_reg[j]  <= ge ? (rem_sh - trial) : rem_sh;
                sq_root_reg[j] <= {src_root[FIELD_W-2:0], ge};
                sq_val_reg[j]  <= {src_val[SQ_IN-3:0], 2'b00};
                sq_zero_reg[j] <= src_zero;
            end
        end
    end

    // A pixel on the centre saturates to 1.0.
    assign out_valid = sq_v_reg[SQ_N-1];
    assign field     = sq_zero_reg[SQ_N-1] ? FIELD_ONE : sq_root_reg[SQ_N-1];

endmodule

`default_nettype wire

FILE: src/mbps_weight.sv
// Weight pipeline: field sum, threshold test and the first field's share.
`default_nettype none

module mbps_weight (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic [mbps_pkg::FIELD_W-1:0] f1,
    input  wire logic [mbps_pkg::FIELD_W-1:0] f2,
    output logic                              out_valid,
    output logic                              above,
    output logic [mbps_pkg::WEIGHT_W-1:0]     weight
);
    import mbps_pkg::*;

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] num_reg;
    logic             thr_reg;
    logic             v0_reg;

    // Sum of the fields and threshold compare.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
        if (en) begin
            sum_reg <= {1'b0, f1} + {1'b0, f2};
            num_reg <= {1'b0, f1};
            thr_reg <= (({1'b0, f1} + {1'b0, f2}) >= SUM_THRESHOLD);
        end
    end

    // Restoring division f1 * 2^16 / sum; f1 is below the sum, so 16 bits suffice.
    logic [SUM_W-1:0]    wd_rem_reg [0:WEIGHT_W-1];
    logic [WEIGHT_W-1:0] wd_quo_reg [0:WEIGHT_W-1];
    logic [SUM_W-1:0]    wd_sum_reg [0:WEIGHT_W-1];
    logic                wd_thr_reg [0:WEIGHT_W-1];
    logic                wd_v_reg   [0:WEIGHT_W-1];

    for (genvar k = 0; k < WEIGHT_W; k++) begin : g_div
        logic [SUM_W-1:0]    src_rem;
        logic [WEIGHT_W-1:0] src_quo;
        logic [SUM_W-1:0]    src_sum;
        logic                src_thr;
        logic                src_v;
        logic [SUM_W:0]      shifted;
        logic [SUM_W:0]      diff;
        logic                ge;

        if (k == 0) begin : g_first
            assign src_rem = num_reg;
            assign src_quo = '0;
            assign src_sum = sum_reg;
            assign src_thr = thr_reg;
            assign src_v   = v0_reg;
        end else begin : g_rest
            assign src_rem = wd_rem_reg[k-1];
            assign src_quo = wd_quo_reg[k-1];
            assign src_sum = wd_sum_reg[k-1];
            assign src_thr = wd_thr_reg[k-1];
            assign src_v   = wd_v_reg[k-1];
        end

        assign shifted = {src_rem, 1'b0};
        assign ge      = (shifted >= {1'b0, src_sum});
        assign diff    = shifted - {1'b0, src_sum};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                wd_v_reg[k] <= 1'b0;
            end else if (en) begin
                wd_v_reg[k] <= src_v;
            end
            if (en) begin
                wd_rem_reg[k] <= ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
                wd_quo_reg[k] <= {src_quo[WEIGHT_W-2:0], ge};
                wd_sum_reg[k] <= src_sum;
                wd_thr_reg[k] <= src_thr;
            end
        end
    end

    assign out_valid = wd_v_reg[WEIGHT_W-1];
    assign above     = wd_thr_reg[WEIGHT_W-1];
    assign weight    = wd_quo_reg[WEIGHT_W-1];

endmodule

`default_nettype wire

FILE: src/metaball_pixel_shader_unit.sv
// Top level of the metaball pixel shader: configuration, field, weight and blend.
// From an accepted item to its result on the output register the pipeline has
// 3 distance stages, 49 division stages and 25 square root stages per ball, 17 weight
// stages and 2 blend stages. Throughput is one item per cycle; the whole pipeline
// advances whenever the output register is empty or being taken.
// Reset clears every valid bit and loads the configuration registers with their defaults.
`default_nettype none

module metaball_pixel_shader_unit #(
    parameter int MAX_WIDTH  = mbps_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = mbps_pkg::DEFAULT_MAX_HEIGHT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mbps_pkg::COLOR_W-1:0]   cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [mbps_pkg::COORD_X_W-1:0] s_pixel_x,
    input  wire logic [mbps_pkg::COORD_Y_W-1:0] s_pixel_y,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [mbps_pkg::COLOR_W-1:0]        m_pixel_color
);
    import mbps_pkg::*;

    localparam int LIM_W = 14;
    localparam logic [LIM_W-1:0] W_LIM = LIM_W'(MAX_WIDTH);
    localparam logic [LIM_W-1:0] H_LIM = LIM_W'(MAX_HEIGHT);
    localparam logic [COORD_X_W-1:0] X_TOP = COORD_X_W'(MAX_WIDTH - 1);
    localparam logic [COORD_Y_W-1:0] Y_TOP = COORD_Y_W'(MAX_HEIGHT - 1);

    logic [COORD_X_W-1:0] first_x_reg;
    logic [COORD_Y_W-1:0] first_y_reg;
    logic [COORD_X_W-1:0] second_x_reg;
    logic [COORD_Y_W-1:0] second_y_reg;
    logic [COLOR_W-1:0]   first_col_reg;
    logic [COLOR_W-1:0]   second_col_reg;
    logic [COLOR_W-1:0]   background_reg;

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_x_reg    <= RST_FIRST_X;
            first_y_reg    <= RST_FIRST_Y;
            second_x_reg   <= RST_SECOND_X;
            second_y_reg   <= RST_SECOND_Y;
            first_col_reg  <= RST_FIRST_COL;
            second_col_reg <= RST_SECOND_COL;
            background_reg <= RST_BACKGROUND;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FIRST_X:    first_x_reg    <= cfg_wdata[COORD_X_W-1:0];
                REG_FIRST_Y:    first_y_reg    <= cfg_wdata[COORD_Y_W-1:0];
                REG_SECOND_X:   second_x_reg   <= cfg_wdata[COORD_X_W-1:0];
                REG_SECOND_Y:   second_y_reg   <= cfg_wdata[COORD_Y_W-1:0];
                REG_FIRST_COL:  first_col_reg  <= cfg_wdata;
                REG_SECOND_COL: second_col_reg <= cfg_wdata;
                REG_BACKGROUND: background_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Coordinates beyond the frame are pulled back to its last row or column.
    function automatic logic [COORD_X_W-1:0] clamp_x(input logic [COORD_X_W-1:0] v);
        logic [LIM_W-1:0] ext;
        begin
            ext = {{(LIM_W - COORD_X_W){1'b0}}, v};
            clamp_x = (ext >= W_LIM) ? X_TOP : v;
        end
    endfunction

    function automatic logic [COORD_Y_W-1:0] clamp_y(input logic [COORD_Y_W-1:0] v);
        logic [LIM_W-1:0] ext;
        begin
            ext = {{(LIM_W - COORD_Y_W){1'b0}}, v};
            clamp_y = (ext >= H_LIM) ? Y_TOP : v;
        end
    endfunction

    // The pipeline moves as one whenever the output register can take a new item.
    logic en;
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    logic                 fv1;
    logic                 fv2;
    logic [FIELD_W-1:0]   f1;
    logic [FIELD_W-1:0]   f2;

    mbps_field u_field_first (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .px        (clamp_x(s_pixel_x)),
        .py        (clamp_y(s_pixel_y)),
        .bx        (clamp_x(first_x_reg)),
        .by        (clamp_y(first_y_reg)),
        .out_valid (fv1),
        .field     (f1)
    );

    mbps_field u_field_second (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .px        (clamp_x(s_pixel_x)),
        .py        (clamp_y(s_pixel_y)),
        .bx        (clamp_x(second_x_reg)),
        .by        (clamp_y(second_y_reg)),
        .out_valid (fv2),
        .field     (f2)
    );

    logic                wv;
    logic                above;
    logic [WEIGHT_W-1:0] weight;

    mbps_weight u_weight (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fv1 && fv2),
        .f1        (f1),
        .f2        (f2),
        .out_valid (wv),
        .above     (above),
        .weight    (weight)
    );

    // Blend products per channel: c1 * (1 - p) and c2 * p.
    localparam int PA_W = CHAN_W + WEIGHT_W + 1;
    localparam int PB_W = CHAN_W + WEIGHT_W;

    logic [PA_W-1:0] pa_reg [0:2];
    logic [PB_W-1:0] pb_reg [0:2];
    logic            bv_reg;
    logic            bthr_reg;
    logic [WEIGHT_W:0] inv_w;

    assign inv_w = {1'b1, {WEIGHT_W{1'b0}}} - {1'b0, weight};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bv_reg <= 1'b0;
        end else if (en) begin
            bv_reg <= wv;
        end
        if (en) begin
            bthr_reg <= above;
            for (int c = 0; c < 3; c++) begin
                pa_reg[c] <= first_col_reg[c*CHAN_W +: CHAN_W] * inv_w;
                pb_reg[c] <= second_col_reg[c*CHAN_W +: CHAN_W] * weight;
            end
        end
    end

    // Output register: blended channels or the background.
    logic [COLOR_W-1:0] blended;
    always_comb begin
        logic [PA_W:0] tot;
        blended = '0;
        for (int c = 0; c < 3; c++) begin
            tot = {1'b0, pa_reg[c]} + {2'b00, pb_reg[c]};
            blended[c*CHAN_W +: CHAN_W] = tot[WEIGHT_W +: CHAN_W];
        end
    end

    logic               m_valid_reg;
    logic [COLOR_W-1:0] color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= bv_reg;
        end
        if (en) begin
            color_reg <= bthr_reg ? blended : background_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_color = color_reg;

endmodule

`default_nettype wire

FILE: src/mbps_checker.sv
// Port-level checker for the metaball pixel shader, bound to the top level.
`default_nettype none

module mbps_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_ready,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic [mbps_pkg::COLOR_W-1:0]   m_pixel_color
);
    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The input side is ready exactly when the output register can move.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (m_ready || !m_valid))
        else $error("input ready disagrees with output stall");

    // A stalled result holds its item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_color))
        else $error("stalled result changed");

    // No result can appear in the cycle after reset is released.
    assert property (@(posedge aclk) $rose(aresetn) |-> !m_valid)
        else $error("result without accepted item");

endmodule

bind metaball_pixel_shader_unit mbps_checker u_mbps_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_pixel_color (m_pixel_color)
);

`default_nettype wire

FILE: tb/sv/tb_metaball_pixel_shader_unit.sv
// Self-checking testbench for the metaball pixel shader: directed table, random pixels, idling.

module tb_metaball_pixel_shader_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mbps_pkg::*;

    localparam int PIPE_LAT  = 96;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1930;

    // Idling modes for the two sides.
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One directed stimulus row: pixel and, where known at a glance, the colour.
    typedef struct {
        logic [COORD_X_W-1:0] px;
        logic [COORD_Y_W-1:0] py;
        bit                   known;
        logic [COLOR_W-1:0]   color;
    } pixel_row_t;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COLOR_W-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic [COORD_X_W-1:0] s_pixel_x;
    logic [COORD_Y_W-1:0] s_pixel_y;
    logic m_valid;
    logic m_ready;
    logic [COLOR_W-1:0] m_pixel_color;

    // Shadow copy of the configuration registers.
    logic [COORD_X_W-1:0] ball1_x, ball2_x;
    logic [COORD_Y_W-1:0] ball1_y, ball2_y;
    logic [COLOR_W-1:0] color1, color2, bg_color;

    logic [COLOR_W-1:0] colour_queue[$];
    idle_mode_t idle_mode;
    int error_count;
    int wdog_count;
    bit hold_off;

    metaball_pixel_shader_unit dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_pixel_x(s_pixel_x),
        .s_pixel_y(s_pixel_y),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_pixel_color(m_pixel_color)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Integer square root, bit by bit.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Field of one ball at a pixel in Q1.24.
    function automatic longint unsigned ball_strength(input longint unsigned px,
            input longint unsigned py, input longint unsigned bx, input longint unsigned by);
        longint unsigned dx, dy, d2;
        dx = (px >= bx) ? px - bx : bx - px;
        dy = (py >= by) ? py - by : by - py;
        d2 = dx * dx + dy * dy;
        if (d2 == 0) return 64'd1 << 24;
        return int_sqrt((64'd1 << 48) / d2);
    endfunction

    // Expected colour of one pixel under the current shadow configuration.
    function automatic logic [COLOR_W-1:0] shade_pixel(input logic [COORD_X_W-1:0] px,
            input logic [COORD_Y_W-1:0] py);
        longint unsigned f1, f2, total, w, c1, c2;
        logic [COLOR_W-1:0] res;
        f1 = ball_strength(px, py, ball1_x, ball1_y);
        f2 = ball_strength(px, py, ball2_x, ball2_y);
        total = f1 + f2;
        if (total < SUM_THRESHOLD) return bg_color;
        w = (f1 << 16) / total;
        if (w > 65535) w = 65535;
        for (int ch = 0; ch < 3; ch++) begin
            c1 = (color1 >> (8 * ch)) & 8'hFF;
            c2 = (color2 >> (8 * ch)) & 8'hFF;
            res[8*ch +: 8] = 8'(((c1 * (65536 - w) + c2 * w) >> 16) & 8'hFF);
        end
        return res;
    endfunction

    // Write one register and mirror it in the shadow copy.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FIRST_X:    ball1_x = val[COORD_X_W-1:0];
            REG_FIRST_Y:    ball1_y = val[COORD_Y_W-1:0];
            REG_SECOND_X:   ball2_x = val[COORD_X_W-1:0];
            REG_SECOND_Y:   ball2_y = val[COORD_Y_W-1:0];
            REG_FIRST_COL:  color1 = val;
            REG_SECOND_COL: color2 = val;
            REG_BACKGROUND: bg_color = val;
            default: ;
        endcase
    endtask

    // Offer one pixel; the prediction is queued as it is accepted.
    // Valid stays high into the next item unless the sender idles or drains.
    task automatic send_pixel(input logic [COORD_X_W-1:0] px, input logic [COORD_Y_W-1:0] py,
            input bit known, input logic [COLOR_W-1:0] color);
        logic [COLOR_W-1:0] predicted;
        if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
            while ($urandom_range(99) < (idle_mode == IDLE_SENDER ? 74 : 19)) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        predicted = known ? color : shade_pixel(px, py);
        s_valid <= 1'b1;
        s_pixel_x <= px;
        s_pixel_y <= py;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        colour_queue.push_back(predicted);
        @(negedge aclk);
    endtask

    // Wait until every result has arrived, then let the pipeline settle.
    task automatic drain;
        s_valid <= 1'b0;
        while (colour_queue.size() != 0) @(negedge aclk);
        repeat (PIPE_LAT + 4) @(negedge aclk);
    endtask

    // Random pixel, biased toward the ball centres and the frame edges.
    task automatic send_random;
        logic [COORD_X_W-1:0] px;
        logic [COORD_Y_W-1:0] py;
        case ($urandom_range(5))
            0: begin
                px = COORD_X_W'(ball1_x + $urandom_range(8) - 4);
                py = COORD_Y_W'(ball1_y + $urandom_range(8) - 4);
            end
            1: begin
                px = COORD_X_W'(ball2_x + $urandom_range(8) - 4);
                py = COORD_Y_W'(ball2_y + $urandom_range(8) - 4);
            end
            2: begin
                px = $urandom_range(1) ? 11'h7FF : 11'h000;
                py = $urandom_range(1) ? 10'h3FF : 10'h000;
            end
            default: begin
                px = COORD_X_W'($urandom);
                py = COORD_Y_W'($urandom);
            end
        endcase
        send_pixel(px, py, 1'b0, '0);
    endtask

    // Receiver stalls, with a long hold-off on request.
    always @(negedge aclk) begin
        if (!aresetn || hold_off) begin
            m_ready <= 1'b0;
        end else begin
            case (idle_mode)
                IDLE_RECEIVER: m_ready <= ($urandom_range(99) >= 74);
                IDLE_BOTH:     m_ready <= ($urandom_range(99) >= 19);
                default:       m_ready <= 1'b1;
            endcase
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (colour_queue.size() == 0) begin
                $display("%0t: unexpected pixel_color actual %06h", $time, m_pixel_color);
                error_count++;
            end else begin
                if (m_pixel_color !== colour_queue[0]) begin
                    $display("%0t: pixel_color expected %06h actual %06h",
                             $time, colour_queue[0], m_pixel_color);
                    error_count++;
                end
                void'(colour_queue.pop_front());
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            wdog_count <= 0;
        else
            wdog_count <= wdog_count + 1;
        if (wdog_count >= WDOG_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Main stimulus sequence.
    initial begin
        pixel_row_t rows[$];
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_pixel_x = '0;
        s_pixel_y = '0;
        hold_off = 1'b0;
        idle_mode = IDLE_NONE;
        ball1_x = RST_FIRST_X;
        ball1_y = RST_FIRST_Y;
        ball2_x = RST_SECOND_X;
        ball2_y = RST_SECOND_Y;
        color1 = RST_FIRST_COL;
        color2 = RST_SECOND_COL;
        bg_color = RST_BACKGROUND;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part with reset configuration: centres, corners, far field.
        rows.push_back('{11'd200, 10'd200, 1'b0, '0});
        rows.push_back('{11'd800, 10'd450, 1'b0, '0});
        rows.push_back('{11'd0, 10'd0, 1'b0, '0});
        rows.push_back('{11'h7FF, 10'h3FF, 1'b0, '0});
        rows.push_back('{11'h7FF, 10'd0, 1'b0, '0});
        rows.push_back('{11'd0, 10'h3FF, 1'b0, '0});
        rows.push_back('{11'd500, 10'd325, 1'b0, '0});
        rows.push_back('{11'h555, 10'h2AA, 1'b0, '0});
        rows.push_back('{11'h2AA, 10'h155, 1'b0, '0});
        foreach (rows[i]) send_pixel(rows[i].px, rows[i].py, rows[i].known, rows[i].color);
        drain();

        // Balls far apart in opposite corners, distinct colours for each.
        write_reg(REG_FIRST_X, 24'h0);
        write_reg(REG_FIRST_Y, 24'h0);
        write_reg(REG_SECOND_X, 24'h7FF);
        write_reg(REG_SECOND_Y, 24'h3FF);
        write_reg(REG_FIRST_COL, 24'hFFFFFF);
        write_reg(REG_SECOND_COL, 24'h000000);
        write_reg(REG_BACKGROUND, 24'h123456);
        rows.delete();
        rows.push_back('{11'd0, 10'd0, 1'b0, '0});
        rows.push_back('{11'h7FF, 10'h3FF, 1'b0, '0});
        rows.push_back('{11'd1024, 10'd512, 1'b0, '0});
        rows.push_back('{11'd1, 10'd0, 1'b0, '0});
        rows.push_back('{11'h7FE, 10'h3FF, 1'b0, '0});
        foreach (rows[i]) send_pixel(rows[i].px, rows[i].py, rows[i].known, rows[i].color);
        drain();
        // Both balls on one spot: equal fields give the exact midpoint blend.
        write_reg(REG_SECOND_X, 24'h0);
        write_reg(REG_SECOND_Y, 24'h0);
        write_reg(REG_FIRST_COL, 24'h000000);
        write_reg(REG_SECOND_COL, 24'hFFFFFF);
        send_pixel(11'd0, 10'd0, 1'b1, 24'h7F7F7F);
        send_pixel(11'h7FF, 10'h3FF, 1'b0, '0);
        drain();

        // Random phases over several settings and idling modes.
        for (int ph = 0; ph < 8; ph++) begin
            idle_mode = idle_mode_t'(ph % 4);
            if (ph == 7) begin
                write_reg(REG_FIRST_X, 24'h7FF);
                write_reg(REG_FIRST_Y, 24'h3FF);
                write_reg(REG_SECOND_X, 24'h0);
                write_reg(REG_SECOND_Y, 24'h0);
            end else if (ph != 0) begin
                write_reg(REG_FIRST_X, COLOR_W'($urandom_range(2047)));
                write_reg(REG_FIRST_Y, COLOR_W'($urandom_range(1023)));
                write_reg(REG_SECOND_X, COLOR_W'($urandom_range(2047)));
                write_reg(REG_SECOND_Y, COLOR_W'($urandom_range(1023)));
            end
            write_reg(REG_FIRST_COL, COLOR_W'($urandom));
            write_reg(REG_SECOND_COL, COLOR_W'($urandom));
            write_reg(REG_BACKGROUND, COLOR_W'($urandom));
            if (ph == 2) begin
                // Long receiver hold-off while the sender keeps offering items.
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(negedge aclk);
                        hold_off = 1'b0;
                    end
                    for (int k = 0; k < N_RANDOM / 8; k++) send_random();
                join
            end else begin
                for (int k = 0; k < N_RANDOM / 8; k++) send_random();
            end
            drain();
        end

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
